>>> rtl/fpma_pkg.sv
package fpma_pkg;

  // Field widths
  localparam int ELAPSED_W = 32;
  localparam int PEND_W    = 33;
  localparam int FT_W      = 30;
  localparam int WS_W      = 7;
  localparam int SCALE_W   = 16;
  localparam int SCALED_W  = 38;
  localparam int FPS_W     = 24;
  localparam int FRAME_W   = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 1;

  // Default ring depth
  localparam int DEF_WINDOW_DEPTH = 64;

  // Time constants: one second in ns, and the same in Q8
  localparam logic [FT_W-1:0]     NS_PER_SEC = 30'd1000000000;
  localparam logic [SCALED_W-1:0] NS_Q8      = 38'd256000000000;

  // Register reset values
  localparam logic [FT_W-1:0]    MIN_FRAME_RST  = 30'd0;
  localparam logic [FT_W-1:0]    MAX_FRAME_RST  = 30'd250000000;
  localparam logic [WS_W-1:0]    WINDOW_RST     = 7'd64;
  localparam logic [SCALE_W-1:0] TIME_SCALE_RST = 16'd256;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_FRAME  = 2'd0,
    CFG_MAX_FRAME  = 2'd1,
    CFG_WINDOW     = 2'd2,
    CFG_TIME_SCALE = 2'd3
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PUSH,
    ST_MULT,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_e;

endpackage

>>> rtl/fpma_ram.sv
module fpma_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fpma_div.sv
module fpma_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 30,
  parameter int Q_W   = fpma_pkg::FPS_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int HW    = NUM_W - Q_W;
  localparam int CW    = (HW > DEN_W) ? HW : DEN_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [Q_W-1:0]   lo_q;
  logic [Q_W-1:0]   quot_q;

  logic [CW-1:0]    hi_x;
  logic [CW-1:0]    den_x;
  logic             sat;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Quotient overflows Q_W bits (or divide by zero) when the top part >= divisor
  assign hi_x  = CW'(num_i[NUM_W-1:Q_W]);
  assign den_x = CW'(den_i);
  assign sat   = (hi_x >= den_x);

  // One restoring step a cycle
  assign trial = {rem_q, lo_q[Q_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !sat;
      cnt_q  <= CNT_W'(Q_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= hi_x[DEN_W-1:0];
      lo_q   <= num_i[Q_W-1:0];
      quot_q <= sat ? '1 : '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_q   <= lo_q << 1;
      quot_q <= {quot_q[Q_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/frame_pacer_moving_average_core.sv
// Frame pacer with moving-average frame rate.
// Channels: s_axis carries one tick per beat (ns since the previous tick);
// m_axis returns exactly one result beat per tick, in order. tuser flags a
// completed frame; when it is low every tdata field is zero. cfg_* writes
// one of four registers (min/max frame time, window size, time scale);
// cfg_ready_o is always high and writes belong to idle periods.
// A tick that completes no frame goes from its check straight to the
// result register; a frame tick also writes the ring and forms the window
// product, then waits on the 24-step quotient loop of the two frame-rate
// dividers that run side by side (no wait when both rates saturate).
// One tick is in flight at a time; a new tick is accepted only once the
// previous result has moved to the output register.
// Frame times are kept in a one-port-write, one-port-read ring RAM of
// WINDOW_DEPTH entries; the window sum, head and fill live in flops.
// Reset clears the accumulator, frame count and ring bookkeeping and loads
// the register defaults; no RAM clearing pass is needed.
// When the receiver stalls the result waits in the output register and
// the core holds the following result until that beat is taken.
module frame_pacer_moving_average_core #(
  parameter int WINDOW_DEPTH = fpma_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fpma_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [fpma_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Tick input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fpma_pkg::ELAPSED_W-1:0]   s_axis_tdata,  // [31:0] elapsed_ns
  // Result output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [29:0] frame_time_ns, [67:30] scaled_delta_ns, [91:68] instant_fps,
  // [115:92] average_fps, [147:116] frame_number, [151:148] zero
  output logic [fpma_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [fpma_pkg::OUT_USER_W-1:0]  m_axis_tuser   // [0] frame_ready
);

  import fpma_pkg::*;

  localparam int AW        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W     = FT_W + FW;
  localparam int PROD_W    = FW + FT_W;
  localparam int AVG_NUM_W = PROD_W + 8;
  localparam int MUL_W     = FT_W + SCALE_W;

  // Configuration registers
  logic [FT_W-1:0]    min_frame_q;
  logic [FT_W-1:0]    max_frame_q;
  logic [WS_W-1:0]    window_q;
  logic [SCALE_W-1:0] time_scale_q;

  // Control state
  state_e             state_q, state_d;
  logic [PEND_W-1:0]  pend_q;
  logic [FRAME_W-1:0] frames_q;
  logic [AW-1:0]      head_q;
  logic [FW-1:0]      fill_q;
  logic [SUM_W-1:0]   sum_q;
  logic               m_tvalid_q;

  // Per-item payload
  logic               nofr_q;
  logic               evict_q;
  logic [FT_W-1:0]    ft_q;
  logic [MUL_W-1:0]   scale_q;
  logic [PROD_W-1:0]  prod_q;
  logic [OUT_DATA_W-1:0] m_tdata_q;
  logic [OUT_USER_W-1:0] m_tuser_q;

  // Sequencer controls
  logic accept;
  logic ram_re;
  logic ram_we;
  logic div_start;
  logic out_load;

  // Datapath
  logic [PEND_W-1:0] min_x, max_x, clamp, rem;
  logic              no_frame;
  logic [FW-1:0]     weff;
  logic              evict_c;
  logic [FT_W-1:0]   ram_rdata;
  logic [SUM_W-1:0]  sub;
  logic [AW-1:0]     head_inc, head_n, tail;
  logic [FW-1:0]     fill_e, fill_n;
  logic [FW:0]       tail_sum;
  logic [SUM_W-1:0]  sum_n;
  logic              busy_inst, busy_avg;
  logic [FPS_W-1:0]  inst_fps, avg_fps;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_frame_q  <= MIN_FRAME_RST;
      max_frame_q  <= MAX_FRAME_RST;
      window_q     <= WINDOW_RST;
      time_scale_q <= TIME_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_MIN_FRAME:  min_frame_q  <= cfg_data_i[FT_W-1:0];
        CFG_MAX_FRAME:  max_frame_q  <= cfg_data_i[FT_W-1:0];
        CFG_WINDOW:     window_q     <= cfg_data_i[WS_W-1:0];
        CFG_TIME_SCALE: time_scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Threshold, clamp and remainder
  assign min_x    = PEND_W'(min_frame_q);
  assign max_x    = PEND_W'(max_frame_q);
  assign no_frame = (pend_q <= min_x);
  assign clamp    = (pend_q > max_x) ? max_x : pend_q;
  assign rem      = ((min_frame_q != '0) && (clamp > min_x)) ? clamp - min_x : '0;

  // Effective window: zero acts as one, capped at the ring depth
  always_comb begin
    if (window_q == '0) begin
      weff = FW'(1);
    end else if (32'(window_q) > 32'(WINDOW_DEPTH)) begin
      weff = FW'(WINDOW_DEPTH);
    end else begin
      weff = FW'(window_q);
    end
  end
  assign evict_c = (fill_q >= weff);

  // Ring update: drop the oldest entry if full, append at the tail
  assign head_inc = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_n   = evict_q ? head_inc : head_q;
  assign fill_e   = evict_q ? fill_q - 1'b1 : fill_q;
  assign fill_n   = fill_e + 1'b1;
  assign sub      = evict_q ? SUM_W'(ram_rdata) : '0;
  assign sum_n    = sum_q - sub + SUM_W'(ft_q);
  assign tail_sum = (FW + 1)'(head_n) + (FW + 1)'(fill_e);
  assign tail     = (tail_sum >= (FW + 1)'(WINDOW_DEPTH)) ?
                    AW'(tail_sum - (FW + 1)'(WINDOW_DEPTH)) : AW'(tail_sum);

  fpma_ram #(
    .WIDTH (FT_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail),
    .wdata_i (ft_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Frame-rate dividers
  fpma_div #(
    .NUM_W (SCALED_W),
    .DEN_W (FT_W),
    .Q_W   (FPS_W)
  ) u_div_inst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NS_Q8),
    .den_i   (ft_q),
    .busy_o  (busy_inst),
    .quot_o  (inst_fps)
  );

  fpma_div #(
    .NUM_W (AVG_NUM_W),
    .DEN_W (SUM_W),
    .Q_W   (FPS_W)
  ) u_div_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({prod_q, 8'b0}),
    .den_i   (sum_q),
    .busy_o  (busy_avg),
    .quot_o  (avg_fps)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    accept        = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          accept  = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (no_frame) begin
          state_d = ST_DONE;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ram_we  = 1'b1;
        state_d = ST_MULT;
      end
      ST_MULT: begin
        state_d = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (!busy_inst && !busy_avg) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Accumulator, frame count and ring bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      frames_q <= '0;
      head_q   <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
    end else begin
      if (accept) begin
        pend_q <= pend_q + PEND_W'(s_axis_tdata);
      end
      if (state_q == ST_CHECK && !no_frame) begin
        pend_q   <= rem;
        frames_q <= frames_q + 1'b1;
      end
      if (ram_we) begin
        head_q <= head_n;
        fill_q <= fill_n;
        sum_q  <= sum_n;
      end
    end
  end

  // Per-item payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      nofr_q  <= no_frame;
      evict_q <= evict_c;
      ft_q    <= clamp[FT_W-1:0];
      scale_q <= MUL_W'(clamp[FT_W-1:0]) * MUL_W'(time_scale_q);
    end
    if (state_q == ST_MULT) begin
      prod_q <= PROD_W'(fill_q) * PROD_W'(NS_PER_SEC);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tuser_q <= OUT_USER_W'(!nofr_q);
      if (nofr_q) begin
        m_tdata_q <= '0;
      end else begin
        m_tdata_q <= {4'b0, frames_q, avg_fps, inst_fps,
                      scale_q[MUL_W-1:8], ft_q};
      end
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule
